// ===== rtl/leib_pkg.sv =====
// Shared constants, types and index helpers for the line edit input buffer.
// No dependencies; the buffer and the testbench import this package.
package leib_pkg;

  // Ring geometry. Indices count modulo twice the ring depth.
  localparam int RING_DEPTH = 128;
  localparam int ADDR_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int IDX_MOD    = 2 * RING_DEPTH;
  localparam int IDX_W      = $clog2(IDX_MOD);

  // Item operation codes.
  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Echo kinds.
  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_BYTE  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  // Read status codes.
  localparam logic [2:0] RD_NONE  = 3'd0;
  localparam logic [2:0] RD_EMPTY = 3'd1;
  localparam logic [2:0] RD_BYTE  = 3'd2;
  localparam logic [2:0] RD_EOL   = 3'd3;
  localparam logic [2:0] RD_EOF   = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CTRL_D = 8'h04;
  localparam logic [7:0] CH_CTRL_H = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_CTRL_P = 8'h10;
  localparam logic [7:0] CH_CTRL_T = 8'h14;
  localparam logic [7:0] CH_CTRL_U = 8'h15;
  localparam logic [7:0] CH_DEL    = 8'h7f;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // One result item.
  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_byte;
    logic [7:0] erase_count;
    logic       line_committed;
    logic [2:0] read_status;
    logic [7:0] read_byte;
  } result_t;

  // Next index, wrapping at twice the ring depth.
  function automatic idx_t idx_inc(idx_t a);
    idx_t r;
    if (a == IDX_W'(IDX_MOD - 1)) r = '0;
    else r = a + idx_t'(1);
    return r;
  endfunction

  // Previous index, wrapping at twice the ring depth.
  function automatic idx_t idx_dec(idx_t a);
    idx_t r;
    if (a == '0) r = IDX_W'(IDX_MOD - 1);
    else r = a - idx_t'(1);
    return r;
  endfunction

  // Distance from b up to a, in the index space.
  function automatic idx_t idx_diff(idx_t a, idx_t b);
    logic [IDX_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (d[IDX_W]) d = d + (IDX_W+1)'(IDX_MOD);
    return d[IDX_W-1:0];
  endfunction

  // Ring address of an index.
  function automatic addr_t idx_addr(idx_t a);
    idx_t r;
    if (a >= IDX_W'(RING_DEPTH)) r = a - IDX_W'(RING_DEPTH);
    else r = a;
    return r[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/leib_req_if.sv =====
// Input channel of the line edit input buffer: valid/ready plus one item.
// Depends on nothing.
interface leib_req_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_char;
  logic       read_starts;

  modport source (output valid, output op, output rx_char, output read_starts,
                  input ready);
  modport sink (input valid, input op, input rx_char, input read_starts,
                output ready);
endinterface

// ===== rtl/leib_rsp_if.sv =====
// Result channel of the line edit input buffer: valid/ready plus one item.
// Depends on nothing.
interface leib_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] echo_kind;
  logic [7:0] echo_byte;
  logic [7:0] erase_count;
  logic       line_committed;
  logic [2:0] read_status;
  logic [7:0] read_byte;

  modport source (output valid, output echo_kind, output echo_byte, output erase_count,
                  output line_committed, output read_status, output read_byte,
                  input ready);
  modport sink (input valid, input echo_kind, input echo_byte, input erase_count,
                input line_committed, input read_status, input read_byte,
                output ready);
endinterface

// ===== rtl/line_edit_input_buffer.sv =====
// Line edit input buffer: ring of received characters with read, commit and edit indices.
// Depends on leib_pkg, leib_req_if and leib_rsp_if.
//
// Timing: a received character's result item follows in the cycle after it is accepted;
// a read request's result passes the ring read data register, then the output register.
// Throughput: one character per cycle while results are taken; a read request holds off
// new items until the single synchronous ring memory has returned its registered byte.
// Reset: rst clears all three indices and the control state; the ring contents are
// left as they are and only committed entries are ever read.
module line_edit_input_buffer (
  input  logic     clk,
  input  logic     rst,
  leib_req_if.sink   req,
  leib_rsp_if.source rsp
);
  import leib_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic    state;
  idx_t    read_index;
  idx_t    commit_index;
  idx_t    edit_index;
  logic    starts_q;
  logic    out_valid;
  result_t out_data;

  logic [7:0] line_ring [RING_DEPTH];
  logic [7:0] rd_data;
  logic       wr_en;
  addr_t      wr_addr;
  logic [7:0] wr_byte;
  logic       rd_en;

  logic    accept;
  logic    out_free;
  result_t rx_result;
  result_t rd_result;
  idx_t    edit_index_next;
  idx_t    commit_index_next;
  idx_t    read_index_next;
  idx_t    pending;
  logic    ring_has_room;
  logic [7:0] stored;
  idx_t    edit_inc;

  // Handshake: one item at a time, and only with room in the output register.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;

  // Character path: edit the line and decide the echo.
  assign pending       = idx_diff(edit_index, commit_index);
  assign ring_has_room = idx_diff(edit_index, read_index) < IDX_W'(RING_DEPTH);
  assign stored        = (req.rx_char == CH_CR) ? CH_LF : req.rx_char;
  assign edit_inc      = idx_inc(edit_index);

  always_comb begin
    rx_result         = '0;
    edit_index_next   = edit_index;
    commit_index_next = commit_index;
    wr_en             = 1'b0;
    wr_addr           = idx_addr(edit_index);
    wr_byte           = stored;
    if (accept && req.op == OP_RX) begin
      case (req.rx_char)
        CH_CTRL_P, CH_CTRL_T, CH_NUL: begin
        end
        CH_CTRL_U: begin
          if (pending != '0) begin
            edit_index_next       = commit_index;
            rx_result.echo_kind   = ECHO_ERASE;
            if ({1'b0, pending} > (IDX_W+1)'(255)) rx_result.erase_count = 8'd255;
            else rx_result.erase_count = 8'((IDX_W+1)'(pending));
          end
        end
        CH_CTRL_H, CH_DEL: begin
          if (pending != '0) begin
            edit_index_next       = idx_dec(edit_index);
            rx_result.echo_kind   = ECHO_ERASE;
            rx_result.erase_count = 8'd1;
          end
        end
        default: begin
          if (ring_has_room) begin
            wr_en                 = 1'b1;
            edit_index_next       = edit_inc;
            rx_result.echo_kind   = ECHO_BYTE;
            rx_result.echo_byte   = stored;
            if (stored == CH_LF || stored == CH_CTRL_D ||
                idx_diff(edit_inc, read_index) == IDX_W'(RING_DEPTH)) begin
              commit_index_next        = edit_inc;
              rx_result.line_committed = 1'b1;
            end
          end
        end
      endcase
    end
  end

  // Read path: the ring byte is registered when the request is taken.
  assign rd_en = accept && req.op == OP_READ;

  always_comb begin
    rd_result       = '0;
    read_index_next = read_index;
    if (state == ST_READ) begin
      if (read_index == commit_index) begin
        rd_result.read_status = RD_EMPTY;
      end else if (rd_data == CH_CTRL_D) begin
        if (starts_q) read_index_next = idx_inc(read_index);
        rd_result.read_status = RD_EOF;
      end else begin
        read_index_next       = idx_inc(read_index);
        rd_result.read_byte   = rd_data;
        rd_result.read_status = (rd_data == CH_LF) ? RD_EOL : RD_BYTE;
      end
    end
  end

  // Ring memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) line_ring[wr_addr] <= wr_byte;
    if (rd_en) rd_data <= line_ring[idx_addr(read_index)];
  end

  // Control state and indices.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      read_index   <= '0;
      commit_index <= '0;
      edit_index   <= '0;
      out_valid    <= 1'b0;
    end else begin
      read_index   <= read_index_next;
      commit_index <= commit_index_next;
      edit_index   <= edit_index_next;
      if (rd_en) state <= ST_READ;
      else if (state == ST_READ) state <= ST_IDLE;
      if ((accept && req.op == OP_RX) || state == ST_READ) out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Output register payload and the read call flag.
  always_ff @(posedge clk) begin
    if (rd_en) starts_q <= req.read_starts;
    if (accept && req.op == OP_RX) out_data <= rx_result;
    else if (state == ST_READ) out_data <= rd_result;
  end

  assign rsp.valid          = out_valid;
  assign rsp.echo_kind      = out_data.echo_kind;
  assign rsp.echo_byte      = out_data.echo_byte;
  assign rsp.erase_count    = out_data.erase_count;
  assign rsp.line_committed = out_data.line_committed;
  assign rsp.read_status    = out_data.read_status;
  assign rsp.read_byte      = out_data.read_byte;

  // The output register is always empty while a read waits on the ring.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid) else $error("output busy during ring read");

  // A taken read request moves to the ring read state next cycle.
  a_read_follows: assert property (@(posedge clk) disable iff (rst)
    rd_en |=> state == ST_READ) else $error("read request lost");

  // The ring never holds more than its depth.
  a_ring_bound: assert property (@(posedge clk) disable iff (rst)
    idx_diff(edit_index, read_index) <= IDX_W'(RING_DEPTH))
    else $error("ring overfilled");

  // Committed bytes never run past the edited ones.
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    idx_diff(commit_index, read_index) <= idx_diff(edit_index, read_index))
    else $error("commit index beyond edit index");

  // The ring is only written on a received character.
  a_write_on_rx: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (accept && req.op == OP_RX && rsp.valid == out_valid))
    else $error("stray ring write");

endmodule

// ===== tb/line_edit_input_buffer_tb.sv =====
`timescale 1ns / 1ps
// Testbench for line_edit_input_buffer: line editing, ring fill, reads and end of file.
// Depends on leib_pkg, leib_req_if, leib_rsp_if and the line_edit_input_buffer RTL.
module line_edit_input_buffer_tb;
  import leib_pkg::*;

  logic clk = 1'b0;
  logic rst;

  leib_req_if req ();
  leib_rsp_if rsp ();

  line_edit_input_buffer uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Console state as the block should hold it.
  logic [7:0] line_mem [RING_DEPTH];
  int         rd_idx;
  int         cm_idx;
  int         ed_idx;

  result_t expected_results [$];
  int      mismatches   = 0;
  int      items_sent   = 0;
  int      results_seen = 0;
  int      lines_seen   = 0;
  int      eof_seen     = 0;
  bit      src_gaps     = 1'b1;
  bit      sink_stalls  = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Distance from b up to a in the index space.
  function automatic int ring_dist(int a, int b);
    return (a + IDX_MOD - b) % IDX_MOD;
  endfunction

  // Applies one item to the console state and returns the result it should give.
  function automatic result_t console_step(logic op, logic [7:0] ch, logic starts);
    result_t    r;
    logic [7:0] c;
    int         n;
    r = '0;
    c = ch;
    if (op == OP_RX) begin
      if (c == CH_CTRL_P || c == CH_CTRL_T) begin
        // Ignored control characters.
      end else if (c == CH_CTRL_U) begin
        n = ring_dist(ed_idx, cm_idx);
        if (n != 0) begin
          ed_idx = cm_idx;
          r.echo_kind = ECHO_ERASE;
          r.erase_count = (n > 255) ? 8'd255 : 8'(n);
        end
      end else if (c == CH_CTRL_H || c == CH_DEL) begin
        if (ed_idx != cm_idx) begin
          ed_idx = (ed_idx + IDX_MOD - 1) % IDX_MOD;
          r.echo_kind = ECHO_ERASE;
          r.erase_count = 8'd1;
        end
      end else if (c != CH_NUL && ring_dist(ed_idx, rd_idx) < RING_DEPTH) begin
        if (c == CH_CR) c = CH_LF;
        r.echo_kind = ECHO_BYTE;
        r.echo_byte = c;
        line_mem[ed_idx % RING_DEPTH] = c;
        ed_idx = (ed_idx + 1) % IDX_MOD;
        if (c == CH_LF || c == CH_CTRL_D || ring_dist(ed_idx, rd_idx) == RING_DEPTH) begin
          cm_idx = ed_idx;
          r.line_committed = 1'b1;
        end
      end
    end else begin
      if (rd_idx == cm_idx) begin
        r.read_status = RD_EMPTY;
      end else begin
        c = line_mem[rd_idx % RING_DEPTH];
        if (c == CH_CTRL_D) begin
          // End of file is consumed only when it opens a read call.
          if (starts) rd_idx = (rd_idx + 1) % IDX_MOD;
          r.read_status = RD_EOF;
        end else begin
          rd_idx = (rd_idx + 1) % IDX_MOD;
          r.read_byte = c;
          r.read_status = (c == CH_LF) ? RD_EOL : RD_BYTE;
        end
      end
    end
    return r;
  endfunction

  // A character that the block stores and echoes as it is.
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(255));
    end while (c == CH_NUL || c == CH_CTRL_D || c == CH_CTRL_H || c == CH_LF ||
               c == CH_CR || c == CH_CTRL_P || c == CH_CTRL_T || c == CH_CTRL_U ||
               c == CH_DEL);
    return c;
  endfunction

  // Sends one item and records the result that it should produce.
  task automatic send_item(input logic op, input logic [7:0] ch, input logic starts,
                           output result_t expd);
    while (src_gaps && $urandom_range(99) < 16) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
    @(negedge clk);
    req.valid = 1'b1;
    req.op = op;
    req.rx_char = ch;
    req.read_starts = starts;
    do @(posedge clk); while (req.ready !== 1'b1);
    expd = console_step(op, ch, starts);
    expected_results.push_back(expd);
    items_sent++;
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic wait_drain();
    @(negedge clk);
    req.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Result side stalls at random.
  always @(negedge clk) begin
    rsp.ready = !(sink_stalls && $urandom_range(99) < 16);
  end

  function automatic void check_field(string field, logic [7:0] expv, logic [7:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0d, got %0d", field, expv, actv);
      mismatches++;
    end
  endfunction

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk) begin
    result_t e;
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result item arrived with no expectation pending");
        mismatches++;
      end else begin
        e = expected_results.pop_front();
        check_field("echo_kind", 8'(e.echo_kind), 8'(rsp.echo_kind));
        check_field("echo_byte", e.echo_byte, rsp.echo_byte);
        check_field("erase_count", e.erase_count, rsp.erase_count);
        check_field("line_committed", 8'(e.line_committed), 8'(rsp.line_committed));
        check_field("read_status", 8'(e.read_status), 8'(rsp.read_status));
        check_field("read_byte", e.read_byte, rsp.read_byte);
        if (e.line_committed) lines_seen++;
        if (e.read_status == RD_EOF) eof_seen++;
      end
    end
  end

  // Reads and edits on an empty buffer, and the ignored characters.
  task automatic test_empty_and_ignored();
    result_t r;
    send_item(OP_READ, CH_NUL, 1'b1, r);
    send_item(OP_READ, 8'hff, 1'b0, r);
    send_item(OP_RX, CH_NUL, 1'b1, r);
    send_item(OP_RX, CH_CTRL_P, 1'b0, r);
    send_item(OP_RX, CH_CTRL_T, 1'b0, r);
    send_item(OP_RX, CH_CTRL_H, 1'b0, r);
    send_item(OP_RX, CH_DEL, 1'b0, r);
    send_item(OP_RX, CH_CTRL_U, 1'b0, r);
    wait_drain();
  endtask

  // Typing with backspace and kill-line, then a carriage return and a read call.
  task automatic test_line_editing();
    result_t r;
    send_item(OP_RX, 8'h61, 1'b0, r);
    send_item(OP_RX, 8'hff, 1'b1, r);
    send_item(OP_RX, 8'h80, 1'b0, r);
    send_item(OP_RX, CH_CTRL_H, 1'b0, r);
    send_item(OP_RX, CH_CTRL_U, 1'b0, r);
    send_item(OP_RX, 8'h01, 1'b0, r);
    send_item(OP_RX, CH_CR, 1'b0, r);
    send_item(OP_READ, CH_NUL, 1'b1, r);
    send_item(OP_READ, CH_NUL, 1'b0, r);
    wait_drain();
  endtask

  // Control-D inside a line ends the read call but stays until a new call takes it.
  task automatic test_end_of_file();
    result_t r;
    send_item(OP_RX, 8'h7a, 1'b0, r);
    send_item(OP_RX, CH_CTRL_D, 1'b0, r);
    send_item(OP_READ, CH_NUL, 1'b1, r);
    send_item(OP_READ, CH_NUL, 1'b0, r);
    send_item(OP_READ, CH_NUL, 1'b1, r);
    send_item(OP_READ, CH_NUL, 1'b1, r);
    wait_drain();
  endtask

  // Largest kill, then a full ring that commits itself and drops what follows.
  task automatic test_ring_full();
    result_t r;
    repeat (RING_DEPTH - 1) send_item(OP_RX, rand_plain(), 1'($urandom_range(1)), r);
    send_item(OP_RX, CH_CTRL_U, 1'b0, r);
    repeat (RING_DEPTH) send_item(OP_RX, rand_plain(), 1'b0, r);
    send_item(OP_RX, rand_plain(), 1'b0, r);
    send_item(OP_RX, CH_CTRL_D, 1'b0, r);
    send_item(OP_RX, CH_CR, 1'b0, r);
    send_item(OP_RX, CH_DEL, 1'b0, r);
    send_item(OP_RX, CH_CTRL_U, 1'b0, r);
    for (int k = 0; k < RING_DEPTH + 1; k++) begin
      send_item(OP_READ, 8'($urandom_range(255)), (k == 0) ? 1'b1 : 1'($urandom_range(1)), r);
    end
    wait_drain();
  endtask

  // Random typed lines and read calls, mixed with arbitrary items.
  task automatic test_random_sessions();
    result_t    r;
    int         choice;
    int         len;
    int         p;
    int         cap;
    logic [7:0] c;
    bit         drained = 1'b0;
    while (items_sent < 650) begin
      // One long stretch runs with no idling on either side.
      src_gaps = !(items_sent >= 430 && items_sent < 560);
      sink_stalls = src_gaps;
      if (!drained && items_sent >= 590) begin
        wait_drain();
        drained = 1'b1;
      end
      choice = $urandom_range(99);
      if (choice < 15) begin
        send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)), r);
      end else if (choice < 60) begin
        len = $urandom_range(12);
        for (int k = 0; k < len; k++) begin
          p = $urandom_range(99);
          if (p < 78) c = rand_plain();
          else if (p < 84) c = CH_CTRL_H;
          else if (p < 88) c = CH_DEL;
          else if (p < 91) c = CH_CTRL_U;
          else if (p < 94) c = ($urandom_range(1) != 0) ? CH_CTRL_P : CH_NUL;
          else c = 8'($urandom_range(255));
          send_item(OP_RX, c, 1'($urandom_range(1)), r);
        end
        p = $urandom_range(99);
        if (p < 50) send_item(OP_RX, CH_CR, 1'b0, r);
        else if (p < 80) send_item(OP_RX, CH_LF, 1'b0, r);
        else if (p < 95) send_item(OP_RX, CH_CTRL_D, 1'b0, r);
      end else begin
        // A read call takes bytes until the line, the data or the file ends, or its cap is reached.
        cap = $urandom_range(1, 40);
        for (int k = 0; k < cap; k++) begin
          send_item(OP_READ, 8'($urandom_range(255)), (k == 0), r);
          if (r.read_status != RD_BYTE) break;
        end
      end
    end
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.op = OP_RX;
    req.rx_char = CH_NUL;
    req.read_starts = 1'b0;
    rsp.ready = 1'b0;
    for (int k = 0; k < RING_DEPTH; k++) line_mem[k] = '0;
    rd_idx = 0;
    cm_idx = 0;
    ed_idx = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_ignored();
    test_line_editing();
    test_end_of_file();
    test_ring_full();
    test_random_sessions();

    repeat (20) @(posedge clk);
    $display("Sent %0d items and checked %0d results.", items_sent, results_seen);
    $display("Lines committed: %0d, end-of-file reads: %0d.", lines_seen, eof_seen);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Ends a run that hangs.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/leib_pkg.sv
rtl/leib_req_if.sv
rtl/leib_rsp_if.sv
rtl/line_edit_input_buffer.sv
tb/line_edit_input_buffer_tb.sv
